[design/rfba_pkg.sv]
// ----------------------------------------------------------------------------
// rfba_pkg
// Shared types and constants of the radial free block allocator: request and
// response beats, register map, and the command and status bundles between
// the controller and the datapath.
// ----------------------------------------------------------------------------
package rfba_pkg;

	localparam int REQ_TYPE_W  = 2;
	localparam int INDEX_W     = 12;
	localparam int VALUE_W     = 16;
	localparam int COUNT_W     = 13;
	localparam int APB_DATA_W  = 32;
	localparam int APB_ADDR_W  = 5;

	// request codes
	localparam logic [REQ_TYPE_W-1:0] REQ_READ  = 2'd0;
	localparam logic [REQ_TYPE_W-1:0] REQ_WRITE = 2'd1;
	localparam logic [REQ_TYPE_W-1:0] REQ_ALLOC = 2'd2;

	// register indexes
	localparam logic [2:0] REG_MAP_FIRST = 3'd0;
	localparam logic [2:0] REG_MAP_LAST  = 3'd1;
	localparam logic [2:0] REG_COUNT     = 3'd2;
	localparam logic [2:0] REG_LOWER     = 3'd3;
	localparam logic [2:0] REG_FREE      = 3'd4;
	localparam logic [2:0] REG_CHAIN_END = 3'd5;

	typedef struct packed {
		logic [REQ_TYPE_W-1:0] req_type;
		logic [INDEX_W-1:0]    block_index;
		logic [VALUE_W-1:0]    write_value;
	} req_item_t;

	typedef struct packed {
		logic [VALUE_W-1:0] read_value;
		logic [INDEX_W-1:0] granted_block;
		logic               status;
	} rsp_item_t;

	typedef enum logic [1:0] {
		ADDR_REQ   = 2'd0,
		ADDR_RIGHT = 2'd1,
		ADDR_LEFT  = 2'd2
	} addr_sel_t;

	typedef struct packed {
		logic      load_req;
		logic      init_search;
		logic      step_right;
		logic      step_left;
		logic      mem_rd;
		logic      mem_we;
		addr_sel_t addr_sel;
		logic      wr_chain_end;
		logic      res_read;
		logic      res_grant;
		logic      res_full;
		logic      out_load;
	} cmd_t;

	typedef struct packed {
		logic [REQ_TYPE_W-1:0] req_type;
		logic                  r_act;
		logic                  l_act;
		logic                  l_in_depth;
		logic                  match;
		logic                  out_free;
	} sts_t;

endpackage

[design/rfba_ram.sv]
// ----------------------------------------------------------------------------
// rfba_ram
// Generic single-port RAM with write enable and registered read data.
// ----------------------------------------------------------------------------
module rfba_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     re,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

[design/rfba_ctrl.sv]
// ----------------------------------------------------------------------------
// rfba_ctrl
// Request sequencer: decodes each request, walks the alternating right/left
// probe rounds of an allocation and hands the result to the output register.
// ----------------------------------------------------------------------------
module rfba_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  rfba_pkg::sts_t sts,
	output rfba_pkg::cmd_t cmd
);

	typedef enum logic [12:0] {
		S_IDLE  = 13'b0000000000001,
		S_DEC   = 13'b0000000000010,
		S_RD    = 13'b0000000000100,
		S_RDATA = 13'b0000000001000,
		S_WR    = 13'b0000000010000,
		S_INIT  = 13'b0000000100000,
		S_PR    = 13'b0000001000000,
		S_CR    = 13'b0000010000000,
		S_PL    = 13'b0000100000000,
		S_CL    = 13'b0001000000000,
		S_GR    = 13'b0010000000000,
		S_GL    = 13'b0100000000000,
		S_DONE  = 13'b1000000000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.addr_sel = rfba_pkg::ADDR_REQ;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load_req = 1'b1;
					state_d      = S_DEC;
				end
			end
			S_DEC: begin
				if (sts.req_type == rfba_pkg::REQ_READ) begin
					state_d = S_RD;
				end else if (sts.req_type == rfba_pkg::REQ_WRITE) begin
					state_d = S_WR;
				end else if (sts.req_type == rfba_pkg::REQ_ALLOC) begin
					state_d = S_INIT;
				end else begin
					state_d = S_DONE;
				end
			end
			S_RD: begin
				cmd.mem_rd = 1'b1;
				state_d    = S_RDATA;
			end
			S_RDATA: begin
				cmd.res_read = 1'b1;
				state_d      = S_DONE;
			end
			S_WR: begin
				cmd.mem_we = 1'b1;
				state_d    = S_DONE;
			end
			S_INIT: begin
				cmd.init_search = 1'b1;
				state_d         = S_PR;
			end
			S_PR: begin
				cmd.addr_sel = rfba_pkg::ADDR_RIGHT;
				if (sts.r_act) begin
					cmd.mem_rd = 1'b1;
					state_d    = S_CR;
				end else if (sts.l_act) begin
					state_d = S_PL;
				end else begin
					cmd.res_full = 1'b1;
					state_d      = S_DONE;
				end
			end
			S_CR: begin
				if (sts.match) begin
					state_d = S_GR;
				end else begin
					cmd.step_right = 1'b1;
					state_d        = S_PL;
				end
			end
			S_PL: begin
				cmd.addr_sel = rfba_pkg::ADDR_LEFT;
				if (sts.l_act && sts.l_in_depth) begin
					cmd.mem_rd = 1'b1;
					state_d    = S_CL;
				end else begin
					cmd.step_left = sts.l_act;
					state_d       = S_PR;
				end
			end
			S_CL: begin
				if (sts.match) begin
					state_d = S_GL;
				end else begin
					cmd.step_left = 1'b1;
					state_d       = S_PR;
				end
			end
			S_GR: begin
				cmd.addr_sel     = rfba_pkg::ADDR_RIGHT;
				cmd.mem_we       = 1'b1;
				cmd.wr_chain_end = 1'b1;
				cmd.res_grant    = 1'b1;
				state_d          = S_DONE;
			end
			S_GL: begin
				cmd.addr_sel     = rfba_pkg::ADDR_LEFT;
				cmd.mem_we       = 1'b1;
				cmd.wr_chain_end = 1'b1;
				cmd.res_grant    = 1'b1;
				state_d          = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

[design/rfba_dpath.sv]
// ----------------------------------------------------------------------------
// rfba_dpath
// Allocator datapath: request register, right and left search pointers,
// block map RAM, free-marker compare and the pending result.
// ----------------------------------------------------------------------------
module rfba_dpath #(
	parameter int MAP_DEPTH   = 4096,
	parameter int ENTRY_WIDTH = 16
) (
	input  logic                              clk,
	input  logic [rfba_pkg::INDEX_W-1:0]      map_first,
	input  logic [rfba_pkg::INDEX_W-1:0]      map_last,
	input  logic [rfba_pkg::COUNT_W-1:0]      block_count,
	input  logic [rfba_pkg::INDEX_W-1:0]      lower_limit,
	input  logic [rfba_pkg::VALUE_W-1:0]      free_marker,
	input  logic [rfba_pkg::VALUE_W-1:0]      chain_end_marker,
	input  rfba_pkg::req_item_t               req,
	input  rfba_pkg::cmd_t                    cmd,
	output rfba_pkg::sts_t                    sts,
	output rfba_pkg::rsp_item_t               res
);

	localparam int AW = $clog2(MAP_DEPTH);
	localparam int PW = (AW + 1 > rfba_pkg::COUNT_W) ? AW + 1 : rfba_pkg::COUNT_W;
	localparam int LW = rfba_pkg::INDEX_W + 1;
	localparam logic [PW-1:0] DEPTH_W = PW'(MAP_DEPTH);

	rfba_pkg::req_item_t req_q;
	rfba_pkg::rsp_item_t res_q;
	logic [PW-1:0]       right_q;
	logic [LW-1:0]       left_q;

	logic [PW-1:0]          rlimit;
	logic [PW-1:0]          left_w;
	logic [AW-1:0]          mem_addr;
	logic [ENTRY_WIDTH-1:0] mem_wdata;
	logic [ENTRY_WIDTH-1:0] mem_rdata;
	logic [rfba_pkg::INDEX_W-1:0] grant_blk;

	assign rlimit = (PW'(block_count) < DEPTH_W) ? PW'(block_count) : DEPTH_W;
	assign left_w = PW'(left_q[LW-2:0]);

	always_comb begin
		case (cmd.addr_sel)
			rfba_pkg::ADDR_RIGHT: mem_addr = AW'(right_q);
			rfba_pkg::ADDR_LEFT:  mem_addr = AW'(left_w);
			default:              mem_addr = AW'(PW'(req_q.block_index));
		endcase
	end

	assign mem_wdata = cmd.wr_chain_end ? ENTRY_WIDTH'(chain_end_marker)
	                                    : ENTRY_WIDTH'(req_q.write_value);
	assign grant_blk = (cmd.addr_sel == rfba_pkg::ADDR_LEFT) ? left_q[LW-2:0]
	                                                          : rfba_pkg::INDEX_W'(right_q);

	rfba_ram #(
		.WIDTH(ENTRY_WIDTH),
		.DEPTH(MAP_DEPTH)
	) u_map (
		.clk  (clk),
		.re   (cmd.mem_rd),
		.we   (cmd.mem_we),
		.addr (mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q <= req;
			res_q <= '0;
		end
		if (cmd.init_search) begin
			right_q <= PW'(map_last) + PW'(1);
			left_q  <= LW'(map_first) - LW'(1);
		end
		if (cmd.step_right) begin
			right_q <= right_q + PW'(1);
		end
		if (cmd.step_left) begin
			left_q <= left_q - LW'(1);
		end
		if (cmd.res_read) begin
			res_q.read_value <= rfba_pkg::VALUE_W'(mem_rdata);
		end
		if (cmd.res_grant) begin
			res_q.granted_block <= grant_blk;
		end
		if (cmd.res_full) begin
			res_q.status <= 1'b1;
		end
	end

	assign sts.req_type   = req_q.req_type;
	assign sts.r_act      = right_q < rlimit;
	assign sts.l_act      = !left_q[LW-1] && (left_q[LW-2:0] > lower_limit);
	assign sts.l_in_depth = left_w < DEPTH_W;
	assign sts.match      = mem_rdata == ENTRY_WIDTH'(free_marker);
	assign sts.out_free   = 1'b0;
	assign res            = res_q;

endmodule

[design/radial_free_block_allocator_top.sv]
// ----------------------------------------------------------------------------
// radial_free_block_allocator_top
// Block map keeper with nearest-fit allocation around the map region.
//
// Requests arrive on req (valid/ready), one response beat per request leaves
// on rsp (valid/ready). Registers are to be set over the APB port only while
// idle; the block itself does not enforce this. One request is worked at a
// time; a finished response sits in the output register so the next request
// is taken while it waits. Right and left probes of an allocation alternate,
// each a RAM read then a compare on the single RAM port, and a side that is
// no longer active is skipped in a round. A further request is accepted in
// the cycle after the response is loaded.
// Reset clears the control state and sets the registers to their defaults;
// the map contents are undefined until written. While rsp is stalled the
// response is held and a finished next result waits in the sequencer.
// ----------------------------------------------------------------------------
module radial_free_block_allocator_top #(
	parameter int MAP_DEPTH   = 4096,
	parameter int ENTRY_WIDTH = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 req_valid,
	output logic                                 req_ready,
	input  rfba_pkg::req_item_t                  req,
	output logic                                 rsp_valid,
	input  logic                                 rsp_ready,
	output rfba_pkg::rsp_item_t                  rsp,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [rfba_pkg::APB_ADDR_W-1:0]      paddr,
	input  logic [rfba_pkg::APB_DATA_W-1:0]      pwdata,
	output logic [rfba_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                 pready
);

	logic [rfba_pkg::INDEX_W-1:0] map_first_q;
	logic [rfba_pkg::INDEX_W-1:0] map_last_q;
	logic [rfba_pkg::COUNT_W-1:0] block_count_q;
	logic [rfba_pkg::INDEX_W-1:0] lower_limit_q;
	logic [rfba_pkg::VALUE_W-1:0] free_marker_q;
	logic [rfba_pkg::VALUE_W-1:0] chain_end_q;

	logic                rsp_valid_q;
	rfba_pkg::rsp_item_t rsp_q;
	rfba_pkg::rsp_item_t res;
	rfba_pkg::cmd_t      cmd;
	rfba_pkg::sts_t      sts_dp;
	rfba_pkg::sts_t      sts;
	logic [2:0]          reg_idx;
	logic                cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_first_q   <= 12'd1;
			map_last_q    <= 12'd1;
			block_count_q <= 13'd4096;
			lower_limit_q <= 12'd0;
			free_marker_q <= 16'd0;
			chain_end_q   <= 16'hFFFF;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				rfba_pkg::REG_MAP_FIRST: map_first_q   <= pwdata[11:0];
				rfba_pkg::REG_MAP_LAST:  map_last_q    <= pwdata[11:0];
				rfba_pkg::REG_COUNT:     block_count_q <= pwdata[12:0];
				rfba_pkg::REG_LOWER:     lower_limit_q <= pwdata[11:0];
				rfba_pkg::REG_FREE:      free_marker_q <= pwdata[15:0];
				rfba_pkg::REG_CHAIN_END: chain_end_q   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			rfba_pkg::REG_MAP_FIRST: prdata = 32'(map_first_q);
			rfba_pkg::REG_MAP_LAST:  prdata = 32'(map_last_q);
			rfba_pkg::REG_COUNT:     prdata = 32'(block_count_q);
			rfba_pkg::REG_LOWER:     prdata = 32'(lower_limit_q);
			rfba_pkg::REG_FREE:      prdata = 32'(free_marker_q);
			rfba_pkg::REG_CHAIN_END: prdata = 32'(chain_end_q);
			default:                 prdata = '0;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		sts          = sts_dp;
		sts.out_free = !rsp_valid_q || rsp_ready;
	end

	rfba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rfba_dpath #(
		.MAP_DEPTH  (MAP_DEPTH),
		.ENTRY_WIDTH(ENTRY_WIDTH)
	) u_dpath (
		.clk             (clk),
		.map_first       (map_first_q),
		.map_last        (map_last_q),
		.block_count     (block_count_q),
		.lower_limit     (lower_limit_q),
		.free_marker     (free_marker_q),
		.chain_end_marker(chain_end_q),
		.req             (req),
		.cmd             (cmd),
		.sts             (sts_dp),
		.res             (res)
	);

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!rsp_valid_q || rsp_ready))
		else $error("response loaded over a pending beat");

	a_full_grants_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status) |-> (rsp.granted_block == '0))
		else $error("disk full response carries a block number");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request taken while another is in progress");

	a_no_write_and_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(cmd.mem_we || cmd.mem_rd || cmd.load_req))
		else $error("response loaded while the map is still busy");

endmodule

[tb/rfba_map_check.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rfba_map_check
// Watches the request, response and register ports of the radial free block
// allocator. Keeps its own copy of the block map and registers, works out the
// reply for every accepted request beat and compares each response beat with
// the oldest reply due. Hands the failure count and the number of replies
// still due to the testbench top.
// ----------------------------------------------------------------------------
module rfba_map_check
	import rfba_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	input  logic                  req_ready,
	input  req_item_t             req,
	input  logic                  rsp_valid,
	input  logic                  rsp_ready,
	input  rsp_item_t             rsp,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic                  pready,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output int                    fail_count,
	output int                    pending
);

	localparam int MAP_BLOCKS = 4096;

	logic [VALUE_W-1:0] block_map [MAP_BLOCKS];
	logic [INDEX_W-1:0] first_blk;
	logic [INDEX_W-1:0] last_blk;
	logic [COUNT_W-1:0] disk_blocks;
	logic [INDEX_W-1:0] lower_blk;
	logic [VALUE_W-1:0] free_mark;
	logic [VALUE_W-1:0] chain_mark;
	rsp_item_t          replies_due [$];

	function automatic rsp_item_t serve_map_request(input req_item_t r);
		rsp_item_t o;
		int        right;
		int        left;
		int        rlim;
		bit        found;
		o = '0;
		case (r.req_type)
			REQ_READ: begin
				o.read_value = block_map[r.block_index];
			end
			REQ_WRITE: begin
				block_map[r.block_index] = r.write_value;
			end
			REQ_ALLOC: begin
				right = int'(last_blk) + 1;
				left  = int'(first_blk) - 1;
				rlim  = (int'(disk_blocks) > MAP_BLOCKS) ? MAP_BLOCKS : int'(disk_blocks);
				found = 1'b0;
				o.status = 1'b1;
				// right side first, then left, one step further out per round
				while (!found && (left > int'(lower_blk) || right < rlim)) begin
					if (right < rlim) begin
						if (block_map[right] == free_mark) begin
							block_map[right] = chain_mark;
							o.granted_block = right[INDEX_W-1:0];
							found = 1'b1;
						end else begin
							right++;
						end
					end
					if (!found && left > int'(lower_blk)) begin
						if (block_map[left] == free_mark) begin
							block_map[left] = chain_mark;
							o.granted_block = left[INDEX_W-1:0];
							found = 1'b1;
						end else begin
							left--;
						end
					end
				end
				if (found) begin
					o.status = 1'b0;
				end
			end
			default: begin
			end
		endcase
		return o;
	endfunction

	function automatic void check_field(input string field, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			fail_count++;
			$display("%0t %s expected %0h actual %0h", $time, field, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_item_t want;
		if (!arst_n) begin
			first_blk    = 12'd1;
			last_blk     = 12'd1;
			disk_blocks  = 13'd4096;
			lower_blk    = 12'd0;
			free_mark    = 16'h0000;
			chain_mark   = 16'hFFFF;
			replies_due.delete();
			fail_count   = 0;
			pending      = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[APB_ADDR_W-1:2])
					REG_MAP_FIRST: first_blk    = pwdata[INDEX_W-1:0];
					REG_MAP_LAST:  last_blk     = pwdata[INDEX_W-1:0];
					REG_COUNT:     disk_blocks  = pwdata[COUNT_W-1:0];
					REG_LOWER:     lower_blk    = pwdata[INDEX_W-1:0];
					REG_FREE:      free_mark    = pwdata[VALUE_W-1:0];
					REG_CHAIN_END: chain_mark   = pwdata[VALUE_W-1:0];
					default: begin
					end
				endcase
			end
			// response beat first, so a reply is never matched to its own request
			if (rsp_valid && rsp_ready) begin
				if (replies_due.size() == 0) begin
					fail_count++;
					$display("%0t response beat with no reply due: %0h %0h %0h", $time,
						rsp.read_value, rsp.granted_block, rsp.status);
				end else begin
					want = replies_due.pop_front();
					check_field("read_value", 32'(want.read_value), 32'(rsp.read_value));
					check_field("granted_block", 32'(want.granted_block),
						32'(rsp.granted_block));
					check_field("status", 32'(want.status), 32'(rsp.status));
				end
			end
			if (req_valid && req_ready) begin
				replies_due.push_back(serve_map_request(req));
			end
			pending = replies_due.size();
		end
	end

endmodule

[tb/tb_radial_free_block_allocator_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_radial_free_block_allocator_top
// Stimulus and verdict for the radial free block allocator. Runs a short
// directed set of reads, writes, unused codes and allocations, then random
// traffic over a series of register settings, loading each setting's search
// window first, with random gaps and stalls on both beat channels. The map
// check module beside the block predicts and compares every response beat.
// ----------------------------------------------------------------------------
module tb_radial_free_block_allocator_top;
	import rfba_pkg::*;

	localparam logic [REQ_TYPE_W-1:0] REQ_UNUSED = 2'd3;
	localparam int MAP_BLOCKS      = 4096;
	localparam int HOLD_OFF_CYCLES = 300;
	// slowest allocations probe a whole search window
	localparam int CYCLE_LIMIT     = 500000;

	logic                  clk;
	logic                  arst_n;
	logic                  req_valid;
	logic                  req_ready;
	req_item_t             req;
	logic                  rsp_valid;
	logic                  rsp_ready;
	rsp_item_t             rsp;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	int fail_count;
	int pending;
	int cycle_cnt;
	int rx_hold;
	bit rx_burst;

	int                 cur_first;
	int                 cur_last;
	logic [VALUE_W-1:0] cur_free;
	logic [VALUE_W-1:0] cur_chain;
	bit                 loaded [MAP_BLOCKS];

	radial_free_block_allocator_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	rfba_map_check u_map_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// response side, with its own long hold-off when asked
	initial begin : response_sink
		int stall;
		rsp_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (rx_hold > 0) begin
				stall = rx_hold;
				rx_hold = 0;
			end else if (rx_burst) begin
				stall = 0;
			end else begin
				stall = $urandom_range(0, 10);
			end
			if (stall > 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!rsp_valid);
		end
	end

	task automatic apb_write(input logic [2:0] reg_idx, input logic [APB_DATA_W-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic send_req(input req_item_t item, input bit burst);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 10);
		if (item.req_type == REQ_WRITE) begin
			loaded[item.block_index] = 1'b1;
		end
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		do @(posedge clk); while (!req_ready);
	endtask

	task automatic send_fields(input logic [REQ_TYPE_W-1:0] kind, input int idx,
		input logic [VALUE_W-1:0] val);
		req_item_t it;
		it.req_type    = kind;
		it.block_index = idx[INDEX_W-1:0];
		it.write_value = val;
		send_req(it, 1'b0);
	endtask

	// sender holds off until every reply is in and the block is quiet
	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_config(input int first, input int last, input int count, input int lower,
		input logic [VALUE_W-1:0] free_v, input logic [VALUE_W-1:0] chain_v);
		apb_write(REG_MAP_FIRST, first);
		apb_write(REG_MAP_LAST, last);
		apb_write(REG_COUNT, count);
		apb_write(REG_LOWER, lower);
		apb_write(REG_FREE, 32'(free_v));
		apb_write(REG_CHAIN_END, 32'(chain_v));
		cur_first = first;
		cur_last  = last;
		cur_free  = free_v;
		cur_chain = chain_v;
	endtask

	// write every not yet written entry in a range, no idling
	task automatic load_window(input int from, input int upto);
		req_item_t it;
		for (int b = from; b <= upto; b++) begin
			if (!loaded[b]) begin
				it.req_type    = REQ_WRITE;
				it.block_index = b[INDEX_W-1:0];
				it.write_value = ($urandom_range(0, 2) == 0) ? cur_free
					: 16'($urandom_range(0, 65535));
				send_req(it, 1'b1);
			end
		end
	endtask

	// every entry an allocation may probe under this setting
	task automatic load_search_window(input int first, input int last, input int count,
		input int lower);
		int rtop;
		rtop = ((count > MAP_BLOCKS) ? MAP_BLOCKS : count) - 1;
		load_window(last + 1, rtop);
		if (first > 0) begin
			load_window(lower + 1, first - 1);
		end
	endtask

	// mostly just outside the map region, where the search looks
	function automatic logic [INDEX_W-1:0] pick_index();
		int r;
		int b;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			b = $urandom_range(0, MAP_BLOCKS - 1);
		end else if (r == 1) begin
			b = ($urandom_range(0, 1) != 0) ? MAP_BLOCKS - 1 : 0;
		end else if (r < 6) begin
			b = cur_last + 1 + int'($urandom_range(0, 40));
		end else begin
			b = cur_first - 1 - int'($urandom_range(0, 40));
		end
		if (b < 0) b = 0;
		if (b > MAP_BLOCKS - 1) b = MAP_BLOCKS - 1;
		return b[INDEX_W-1:0];
	endfunction

	function automatic logic [VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return cur_free;
			5:             return cur_chain;
			6:             return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
			default:       return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic req_item_t random_req();
		req_item_t it;
		int        r;
		r = $urandom_range(0, 99);
		it.block_index = pick_index();
		it.write_value = pick_value();
		if (r < 30) begin
			it.req_type = REQ_READ;
		end else if (r < 62) begin
			it.req_type = REQ_WRITE;
		end else if (r < 95) begin
			it.req_type = REQ_ALLOC;
		end else begin
			it.req_type = REQ_UNUSED;
		end
		// an entry is only read once written
		if (it.req_type == REQ_READ && !loaded[it.block_index]) begin
			it.req_type = REQ_WRITE;
		end
		return it;
	endfunction

	task automatic config_phase(input int first, input int last, input int count,
		input int lower, input logic [VALUE_W-1:0] free_v, input logic [VALUE_W-1:0] chain_v,
		input int n, input bit squeeze);
		bit burst;
		set_config(first, last, count, lower, free_v, chain_v);
		load_search_window(first, last, count, lower);
		burst    = ($urandom_range(0, 3) == 0);
		rx_burst = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < n; i++) begin
			// long receiver hold-off while requests keep coming
			if (squeeze && i == 10) rx_hold = HOLD_OFF_CYCLES;
			send_req(random_req(), burst || (squeeze && i >= 10 && i < 30));
		end
		drain();
		rx_burst = 1'b0;
	endtask

	task automatic random_setting();
		int f;
		int l;
		int c;
		int lo;
		f = $urandom_range(0, MAP_BLOCKS - 1);
		if ($urandom_range(0, 7) == 0) begin
			l = f - int'($urandom_range(0, 10));
		end else begin
			l = f + int'($urandom_range(0, 3));
		end
		if (l < 0) l = 0;
		if (l > MAP_BLOCKS - 1) l = MAP_BLOCKS - 1;
		c = l + 1 + int'($urandom_range(0, 16));
		if (c > MAP_BLOCKS) c = MAP_BLOCKS;
		lo = f - 1 - int'($urandom_range(0, 16));
		if (lo < 0) lo = 0;
		config_phase(f, l, c, lo,
			($urandom_range(0, 1) != 0) ? 16'h0000 : 16'($urandom_range(0, 65535)),
			16'($urandom_range(0, 65535)), 20, 1'b0);
	endtask

	initial begin : stimulus
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req       <= '0;
		psel      <= 1'b0;
		penable   <= 1'b0;
		pwrite    <= 1'b0;
		paddr     <= '0;
		pwdata    <= '0;
		rx_hold   = 0;
		rx_burst  = 1'b0;
		cur_first = 1;
		cur_last  = 1;
		cur_free  = 16'h0000;
		cur_chain = 16'hFFFF;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_fields(REQ_WRITE, 0, 16'h0000);
		send_fields(REQ_WRITE, MAP_BLOCKS - 1, 16'hFFFF);
		send_fields(REQ_READ, 0, 16'h0000);
		send_fields(REQ_READ, MAP_BLOCKS - 1, 16'hFFFF);
		send_fields(REQ_WRITE, 0, 16'hFFFF);
		send_fields(REQ_WRITE, MAP_BLOCKS - 1, 16'h0000);
		send_fields(REQ_READ, 0, 16'h0000);
		send_fields(REQ_READ, MAP_BLOCKS - 1, 16'h0000);
		send_fields(REQ_UNUSED, MAP_BLOCKS - 1, 16'hFFFF);
		send_fields(REQ_UNUSED, 0, 16'h0000);
		send_fields(REQ_WRITE, 2, 16'h0000);
		send_fields(REQ_WRITE, 3, 16'h0000);
		send_fields(REQ_WRITE, 4, 16'h0000);
		send_fields(REQ_ALLOC, 0, 16'h0000);
		send_fields(REQ_READ, 2, 16'h0000);
		// block 0 lies on the lower bound and the map region is never probed
		send_fields(REQ_WRITE, 0, 16'h0000);
		send_fields(REQ_WRITE, 1, 16'h0000);
		send_fields(REQ_ALLOC, 0, 16'h0000);
		send_fields(REQ_ALLOC, 0, 16'h0000);
		drain();

		// both sides exhausted from the start: disk full
		set_config(0, MAP_BLOCKS - 1, MAP_BLOCKS, MAP_BLOCKS - 1, 16'h0000, 16'hFFFF);
		send_fields(REQ_ALLOC, MAP_BLOCKS - 1, 16'hFFFF);
		send_fields(REQ_ALLOC, 0, 16'h0000);
		send_fields(REQ_READ, MAP_BLOCKS - 1, 16'h0000);
		drain();

		// left start not above the lower bound, right side only
		set_config(5, 8, 12, 4, 16'h0000, 16'h1234);
		send_fields(REQ_WRITE, 4, 16'h0000);
		send_fields(REQ_WRITE, 9, 16'h5555);
		send_fields(REQ_WRITE, 10, 16'h5555);
		send_fields(REQ_WRITE, 11, 16'h0000);
		send_fields(REQ_ALLOC, 0, 16'h0000);
		send_fields(REQ_ALLOC, 0, 16'h0000);
		drain();

		config_phase(1, 1, 48, 0, 16'h0000, 16'hFFFF, 60, 1'b1);
		config_phase(4095, 4095, MAP_BLOCKS, 4050, 16'h0000, 16'hFFFF, 35, 1'b0);
		config_phase(20, 30, 0, 0, 16'hFFFF, 16'h0000, 35, 1'b0);
		config_phase(80, 50, 70, 60, 16'h1234, 16'hBEEF, 35, 1'b0);
		config_phase(3000, 3001, 3030, 2975, 16'h0000, 16'h8001, 35, 1'b0);
		// allocated block keeps the free marker
		config_phase(2048, 2050, 2075, 2025, 16'hA5A5, 16'hA5A5, 35, 1'b0);
		repeat (8) random_setting();

		drain();
		repeat (20) @(posedge clk);
		if (fail_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
